@@ src/skvt_pkg.sv @@
// Package for the sorted key/value table.
// Holds the raw request codes and the classified request operations shared by the front and back ends.
// No dependencies.
`default_nettype none

package skvt_pkg;

  // Raw request type codes as they arrive on the input port.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_DUMP   = 2'd2;

  // Operations after classification by the front end.
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_LOOKUP,
    OP_DUMP,
    OP_NONE
  } op_e;

endpackage

`default_nettype wire

@@ src/skvt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module skvt_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/skvt_front.sv @@
// Front end of the sorted key/value table: accepts requests, classifies them
// and holds them in a two-entry queue for the engine. Depends on skvt_pkg.
`default_nettype none

module skvt_front #(
  parameter int KeyBits   = 32,
  parameter int ValueBits = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [1:0]           req_type_i,
  input  wire logic [KeyBits-1:0]   key_i,
  input  wire logic [ValueBits-1:0] value_i,
  output logic                      req_valid_o,
  input  wire logic                 req_ready_i,
  output skvt_pkg::op_e             req_op_o,
  output logic      [KeyBits-1:0]   req_key_o,
  output logic      [ValueBits-1:0] req_value_o
);
  import skvt_pkg::*;

  op_e                  op_q  [2];
  logic [KeyBits-1:0]   key_q [2];
  logic [ValueBits-1:0] val_q [2];
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [1:0]           count_q, count_d;
  logic                 enq, deq;
  op_e                  op_in;

  // Classify the raw request type.
  always_comb begin
    unique case (req_type_i)
      REQ_INSERT: op_in = OP_INSERT;
      REQ_LOOKUP: op_in = OP_LOOKUP;
      REQ_DUMP:   op_in = OP_DUMP;
      default:    op_in = OP_NONE;
    endcase
  end

  assign full        = (count_q == 2'd2);
  assign enq         = push && !full;
  assign req_valid_o = (count_q != 2'd0);
  assign deq         = req_valid_o && req_ready_i;

  // Pointer and occupancy updates.
  always_comb begin
    wr_ptr_d = enq ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = deq ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (enq && !deq) begin
      count_d = count_q + 2'd1;
    end else if (deq && !enq) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (enq) begin
      op_q[wr_ptr_q]  <= op_in;
      key_q[wr_ptr_q] <= key_i;
      val_q[wr_ptr_q] <= value_i;
    end
  end

  assign req_op_o    = op_q[rd_ptr_q];
  assign req_key_o   = key_q[rd_ptr_q];
  assign req_value_o = val_q[rd_ptr_q];

endmodule

`default_nettype wire

@@ src/skvt_engine.sv @@
// Back end of the sorted key/value table: runs insert, lookup and dump
// sequences over the entry RAM and drives the result register.
// Depends on skvt_pkg and skvt_ram.
`default_nettype none

module skvt_engine #(
  parameter int Capacity  = 64,
  parameter int KeyBits   = 32,
  parameter int ValueBits = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [ValueBits-1:0] cfg_wdata_i,
  input  wire logic                 req_valid_i,
  output logic                      req_ready_o,
  input  wire skvt_pkg::op_e        req_op_i,
  input  wire logic [KeyBits-1:0]   req_key_i,
  input  wire logic [ValueBits-1:0] req_value_i,
  output logic                      empty,
  input  wire logic                 pop,
  output logic                      status_o,
  output logic                      found_o,
  output logic      [KeyBits-1:0]   out_key_o,
  output logic      [ValueBits-1:0] out_value_o,
  output logic      [6:0]           entry_count_o,
  output logic                      last_o
);
  import skvt_pkg::*;

  localparam int AW = $clog2(Capacity);
  localparam int CW = $clog2(Capacity + 1);
  localparam int DW = KeyBits + ValueBits;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_CMP  = 3'd1;
  localparam logic [2:0] S_INS_PUT  = 3'd2;
  localparam logic [2:0] S_LK_PROBE = 3'd3;
  localparam logic [2:0] S_LK_CMP   = 3'd4;
  localparam logic [2:0] S_LK_FIN   = 3'd5;
  localparam logic [2:0] S_DUMP     = 3'd6;
  localparam logic [2:0] S_RESP     = 3'd7;

  localparam logic [CW-1:0] FULL_COUNT = CW'(Capacity);

  logic [2:0]           state_q, state_d;
  logic [CW-1:0]        fill_q, fill_d;
  logic [AW-1:0]        ptr_q, ptr_d;
  logic [AW-1:0]        mid_q, mid_d;
  logic [CW-1:0]        lo_q, lo_d, hi_q, hi_d, mid_c;
  logic                 dv_q, dv_d;
  logic [KeyBits-1:0]   key_q, key_d;
  logic [ValueBits-1:0] val_q, val_d;
  logic [ValueBits-1:0] default_q;
  logic                 res_status_q, res_status_d, res_found_q, res_found_d;
  logic [KeyBits-1:0]   res_key_q, res_key_d;
  logic [ValueBits-1:0] res_val_q, res_val_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_status_q, out_found_q, out_last_q;
  logic [KeyBits-1:0]   out_key_q;
  logic [ValueBits-1:0] out_val_q;
  logic [CW-1:0]        out_count_q;
  logic                 emit, emit_status, emit_found, emit_last, can_emit;
  logic [KeyBits-1:0]   emit_key;
  logic [ValueBits-1:0] emit_val;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [DW-1:0]        ram_wdata, ram_rdata;
  logic [KeyBits-1:0]   rd_key;
  logic [ValueBits-1:0] rd_val;
  logic                 dump_last;

  skvt_ram #(
    .Width(DW),
    .Depth(Capacity)
  ) u_entries (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_key      = ram_rdata[DW-1:ValueBits];
  assign rd_val      = ram_rdata[ValueBits-1:0];
  assign can_emit    = !out_valid_q || pop;
  assign req_ready_o = (state_q == S_IDLE);
  assign mid_c       = lo_q + ((hi_q - lo_q) >> 1);
  assign dump_last   = (CW'(ptr_q) == fill_q - CW'(1));

  // Sequencer for the table operations.
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    ptr_d        = ptr_q;
    mid_d        = mid_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    dv_d         = dv_q;
    key_d        = key_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_key_d    = res_key_q;
    res_val_d    = res_val_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = {key_q, val_q};
    ram_re       = 1'b0;
    ram_raddr    = '0;
    emit         = 1'b0;
    emit_status  = res_status_q;
    emit_found   = res_found_q;
    emit_key     = res_key_q;
    emit_val     = res_val_q;
    emit_last    = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          key_d        = req_key_i;
          val_d        = req_value_i;
          res_status_d = 1'b0;
          res_found_d  = 1'b0;
          res_key_d    = '0;
          res_val_d    = '0;
          unique case (req_op_i)
            OP_INSERT: begin
              if (fill_q == FULL_COUNT) begin
                res_status_d = 1'b1;
                state_d      = S_RESP;
              end else if (fill_q == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {req_key_i, req_value_i};
                fill_d    = fill_q + CW'(1);
                state_d   = S_RESP;
              end else begin
                ptr_d     = AW'(fill_q - CW'(1));
                ram_re    = 1'b1;
                ram_raddr = AW'(fill_q - CW'(1));
                state_d   = S_INS_CMP;
              end
            end
            OP_LOOKUP: begin
              lo_d    = '0;
              hi_d    = fill_q;
              state_d = S_LK_PROBE;
            end
            OP_DUMP: begin
              ptr_d   = '0;
              dv_d    = 1'b0;
              state_d = (fill_q == '0) ? S_RESP : S_DUMP;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      // Walk down from the top, moving larger keys up by one slot.
      S_INS_CMP: begin
        ram_we = 1'b1;
        if (rd_key > key_q) begin
          ram_waddr = ptr_q + AW'(1);
          ram_wdata = ram_rdata;
          if (ptr_q == '0) begin
            state_d = S_INS_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_q - AW'(1);
            ptr_d     = ptr_q - AW'(1);
          end
        end else begin
          ram_waddr = ptr_q + AW'(1);
          fill_d    = fill_q + CW'(1);
          state_d   = S_RESP;
        end
      end

      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        fill_d    = fill_q + CW'(1);
        state_d   = S_RESP;
      end

      // Binary search for the first entry whose key is not below the key.
      S_LK_PROBE: begin
        if (lo_q < hi_q) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(mid_c);
          mid_d     = AW'(mid_c);
          state_d   = S_LK_CMP;
        end else if (lo_q < fill_q) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(lo_q);
          state_d   = S_LK_FIN;
        end else begin
          res_key_d = key_q;
          res_val_d = default_q;
          state_d   = S_RESP;
        end
      end

      S_LK_CMP: begin
        if (rd_key < key_q) begin
          lo_d = CW'(mid_q) + CW'(1);
        end else begin
          hi_d = CW'(mid_q);
        end
        state_d = S_LK_PROBE;
      end

      S_LK_FIN: begin
        res_key_d   = key_q;
        res_found_d = (rd_key == key_q);
        res_val_d   = (rd_key == key_q) ? rd_val : default_q;
        state_d     = S_RESP;
      end

      // Stream entries in order, one read ahead of the result register.
      S_DUMP: begin
        if (!dv_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q;
          dv_d      = 1'b1;
        end else if (can_emit) begin
          emit        = 1'b1;
          emit_status = 1'b0;
          emit_found  = 1'b1;
          emit_key    = rd_key;
          emit_val    = rd_val;
          emit_last   = dump_last;
          if (dump_last) begin
            dv_d    = 1'b0;
            state_d = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_q + AW'(1);
            ptr_d     = ptr_q + AW'(1);
          end
        end
      end

      S_RESP: begin
        if (can_emit) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      default_q   <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      dv_q        <= dv_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        default_q <= cfg_wdata_i;
      end
    end
  end

  // Working and result payload registers. The entry count is captured with
  // the result, since the engine may change the table while it waits.
  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    mid_q        <= mid_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    key_q        <= key_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_key_q    <= res_key_d;
    res_val_q    <= res_val_d;
    if (emit) begin
      out_status_q <= emit_status;
      out_found_q  <= emit_found;
      out_key_q    <= emit_key;
      out_val_q    <= emit_val;
      out_last_q   <= emit_last;
      out_count_q  <= fill_q;
    end
  end

  assign empty         = !out_valid_q;
  assign status_o      = out_status_q;
  assign found_o       = out_found_q;
  assign out_key_o     = out_key_q;
  assign out_value_o   = out_val_q;
  assign entry_count_o = 7'(out_count_q);
  assign last_o        = out_last_q;

`ifndef ASSERT_OFF
  // The fill count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FULL_COUNT)
    else $error("fill count above capacity");
  // An insert that shifts entries only runs on a table with room left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_CMP) |-> (fill_q < FULL_COUNT) && (fill_q != '0))
    else $error("insert shift on full or empty table");
  // A waiting result is never dropped without a pop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> out_valid_q)
    else $error("result lost");
  // A dump never runs over an empty table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> (fill_q != '0))
    else $error("dump of empty table");
`endif

endmodule

`default_nettype wire

@@ src/sorted_key_value_table_top.sv @@
// Sorted key/value table; one request is worked at a time. An insert into an empty
// table writes slot 0 directly, else it moves every larger entry up by one slot; a
// lookup runs a binary search, then reads the slot it settles on unless the key is
// above every entry; a dump streams the entries in key order. Requests wait in a
// 2-entry queue; results leave through a one-entry register. Reset clears the fill
// count, queue and default value; the entry RAM is not cleared.
`default_nettype none

module sorted_key_value_table_top #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [VALUE_BITS-1:0] cfg_wdata_i,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [1:0]            req_type_i,
  input  wire logic [KEY_BITS-1:0]   key_i,
  input  wire logic [VALUE_BITS-1:0] value_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic                       status_o,
  output logic                       found_o,
  output logic      [KEY_BITS-1:0]   out_key_o,
  output logic      [VALUE_BITS-1:0] out_value_o,
  output logic      [6:0]            entry_count_o,
  output logic                       last_o
);
  import skvt_pkg::*;

  logic                  req_valid, req_ready;
  op_e                   req_op;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;

  // Request intake and classification.
  skvt_front #(
    .KeyBits  (KEY_BITS),
    .ValueBits(VALUE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .req_type_i (req_type_i),
    .key_i      (key_i),
    .value_i    (value_i),
    .req_valid_o(req_valid),
    .req_ready_i(req_ready),
    .req_op_o   (req_op),
    .req_key_o  (req_key),
    .req_value_o(req_value)
  );

  // Table engine and result register.
  skvt_engine #(
    .Capacity (CAPACITY),
    .KeyBits  (KEY_BITS),
    .ValueBits(VALUE_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_valid_i  (req_valid),
    .req_ready_o  (req_ready),
    .req_op_i     (req_op),
    .req_key_i    (req_key),
    .req_value_i  (req_value),
    .empty        (empty),
    .pop          (pop),
    .status_o     (status_o),
    .found_o      (found_o),
    .out_key_o    (out_key_o),
    .out_value_o  (out_value_o),
    .entry_count_o(entry_count_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

@@ test/sorted_key_value_table_top_tb.sv @@
// Testbench for the sorted key/value table: random and directed requests
// checked against a behavioral table model. Depends on skvt_pkg and the top.
`timescale 1ns / 100ps

module sorted_key_value_table_top_tb;
  import skvt_pkg::*;

  localparam int CAP = 64;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic        status;
    logic        found;
    logic [31:0] okey;
    logic [31:0] oval;
    logic [6:0]  count;
    logic        last;
  } table_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  req_type_i = '0;
  logic [31:0] key_i = '0;
  logic [31:0] value_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        status_o, found_o, last_o;
  logic [31:0] out_key_o, out_value_o;
  logic [6:0]  entry_count_o;

  sorted_key_value_table_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .push, .full, .req_type_i,
    .key_i, .value_i, .empty, .pop, .status_o, .found_o, .out_key_o,
    .out_value_o, .entry_count_o, .last_o
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the table contents and register.
  logic [31:0]   shadow_keys [CAP];
  logic [31:0]   shadow_vals [CAP];
  int            shadow_fill = 0;
  logic [31:0]   shadow_default = '0;
  table_result_t pending_results[$];
  int            mismatches = 0;
  int            results_seen = 0;
  int            sender_idle_pct = 0;
  int            receiver_stall_pct = 0;
  int            hold_cycles = 0;
  int            items_sent = 0;

  function automatic table_result_t make_result(logic st, logic fd, logic [31:0] k,
                                                logic [31:0] v, logic lst);
    table_result_t r;
    r.status = st;
    r.found = fd;
    r.okey = k;
    r.oval = v;
    r.count = 7'(shadow_fill);
    r.last = lst;
    return r;
  endfunction

  // Compute the table responses to one request and update the shadow copy.
  task automatic apply_table_request(logic [1:0] req, logic [31:0] k, logic [31:0] v);
    int pos;
    pos = 0;
    if (req == REQ_INSERT) begin
      if (shadow_fill >= CAP) begin
        pending_results.push_back(make_result(1'b1, 1'b0, '0, '0, 1'b1));
      end else begin
        while (pos < shadow_fill && shadow_keys[pos] <= k) pos++;
        for (int i = shadow_fill; i > pos; i--) begin
          shadow_keys[i] = shadow_keys[i-1];
          shadow_vals[i] = shadow_vals[i-1];
        end
        shadow_keys[pos] = k;
        shadow_vals[pos] = v;
        shadow_fill++;
        pending_results.push_back(make_result(1'b0, 1'b0, '0, '0, 1'b1));
      end
    end else if (req == REQ_LOOKUP) begin
      while (pos < shadow_fill && shadow_keys[pos] < k) pos++;
      if (pos < shadow_fill && shadow_keys[pos] == k)
        pending_results.push_back(make_result(1'b0, 1'b1, k, shadow_vals[pos], 1'b1));
      else
        pending_results.push_back(make_result(1'b0, 1'b0, k, shadow_default, 1'b1));
    end else if (req == REQ_DUMP && shadow_fill > 0) begin
      for (int i = 0; i < shadow_fill; i++)
        pending_results.push_back(make_result(1'b0, 1'b1, shadow_keys[i], shadow_vals[i],
                                              i == shadow_fill - 1));
    end else begin
      pending_results.push_back(make_result(1'b0, 1'b0, '0, '0, 1'b1));
    end
  endtask

  // Send one request, with random sender idling before it. Push stays high
  // after an accepted request until the next idle cycle or drain.
  task automatic send_request(logic [1:0] req, logic [31:0] k, logic [31:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    req_type_i <= req;
    key_i <= k;
    value_i <= v;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    apply_table_request(req, k, v);
    items_sent++;
  endtask

  // Wait until every expected response has come, then let the block settle.
  task automatic drain_results();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_default(logic [31:0] d);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_default = d;
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Check each accepted response against the oldest expectation.
  always @(posedge clk_i) begin
    table_result_t got, want;
    if (rst_ni && pop && !empty) begin
      got = '{status_o, found_o, out_key_o, out_value_o, entry_count_o, last_o};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic test_directed();
    send_request(REQ_DUMP, '0, '0);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, '0);
    send_request(REQ_UNUSED, 32'h1234, 32'h5678);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, '0, '0);
    send_request(REQ_INSERT, 32'h8000_0000, 32'h1);
    send_request(REQ_INSERT, 32'h8000_0000, 32'h2);
    send_request(REQ_INSERT, 32'h8000_0000, 32'h3);
    send_request(REQ_LOOKUP, 32'h8000_0000, '1);
    send_request(REQ_LOOKUP, '0, '0);
    send_request(REQ_LOOKUP, 32'h7FFF_FFFF, '0);
    send_request(REQ_DUMP, '1, '1);
  endtask

  task automatic test_default_register();
    write_default(32'hFFFF_FFFF);
    send_request(REQ_LOOKUP, 32'h5555_5555, '0);
    write_default(32'hA5A5_5A5A);
    send_request(REQ_LOOKUP, 32'hAAAA_AAAA, '0);
  endtask

  // Random mix; small key range so duplicates and hits are common.
  task automatic test_random(int n, int idle, int stall);
    logic [1:0]  req;
    logic [31:0] k;
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: req = REQ_INSERT;
        5, 6, 7:       req = REQ_LOOKUP;
        8:             req = ($urandom_range(3) == 0) ? REQ_DUMP : REQ_LOOKUP;
        default:       req = ($urandom_range(1) != 0) ? REQ_UNUSED : REQ_INSERT;
      endcase
      k = ($urandom_range(1) != 0) ? 32'($urandom_range(15)) : $urandom();
      send_request(req, k, $urandom());
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  // Fill the table past capacity while the receiver holds off.
  task automatic test_full_table();
    hold_cycles = 400;
    for (int i = 0; i < CAP + 3; i++) send_request(REQ_INSERT, $urandom(), $urandom());
    send_request(REQ_DUMP, '0, '0);
    send_request(REQ_LOOKUP, $urandom(), '0);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_default_register();
    test_random(100, 0, 0);
    test_random(100, 77, 0);
    test_full_table();
    write_default(32'h0);
    drain_results();
    // The table cannot be emptied; keep exercising it full.
    test_random(60, 0, 77);
    test_random(60, 26, 26);
    drain_results();
    $display("Sent %0d requests, checked %0d responses, including a full table",
             items_sent, results_seen);
    $display("and default-value changes under sender and receiver idling.");
    if (mismatches == 0) begin
      $display("PASS sorted_key_value_table_top");
    end else begin
      $display("FAIL sorted_key_value_table_top");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL sorted_key_value_table_top");
    $finish;
  end

endmodule
